// ----- rtl/iidl_pkg.sv -----
package iidl_pkg;

	// payload widths fixed by the word format
	localparam int DATA_W       = 32;
	localparam int POS_W        = 7;
	localparam int REQ_W        = 2;
	localparam int S_TDATA_W    = 40;
	localparam int M_TDATA_W    = 40;

	// default list capacity
	localparam int CAPACITY_DEF = 64;

	// words merged by one first-level read reduction group
	localparam int GROUP_W      = 32;

	// request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

	// shift command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

	// request sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_GRP,
		ST_OUT
	} fsm_t;

endpackage

// ----- rtl/iidl_cell.sv -----
module iidl_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  logic                       clk,
	input  iidl_pkg::cell_ctrl_t       ctrl,
	input  logic [CW-1:0]              pos,
	input  logic [iidl_pkg::DATA_W-1:0] ins_val,
	input  logic [iidl_pkg::DATA_W-1:0] left_data,
	input  logic [iidl_pkg::DATA_W-1:0] right_data,
	output logic [iidl_pkg::DATA_W-1:0] data,
	output logic [iidl_pkg::DATA_W-1:0] rd_word
);
	import iidl_pkg::*;

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] data_nxt;

	// insert: above pos take left neighbor, at pos take new word
	// delete: at or above pos take right neighbor
	always_comb begin
		data_nxt = data_q;
		if (ctrl.ins) begin
			if (IDX > pos) begin
				data_nxt = left_data;
			end else if (IDX == pos) begin
				data_nxt = ins_val;
			end
		end else if (ctrl.del) begin
			if (IDX >= pos) begin
				data_nxt = right_data;
			end
		end
	end

	// entry storage and masked read word
	always_ff @(posedge clk) begin
		data_q <= data_nxt;
		rd_q   <= (IDX == pos) ? data_q : '0;
	end

	assign data    = data_q;
	assign rd_word = rd_q;

endmodule

// ----- rtl/iidl_grp_or.sv -----
module iidl_grp_or #(
	parameter int N = 32,
	parameter int W = 32
) (
	input  logic                clk,
	input  logic [N-1:0][W-1:0] words,
	output logic [W-1:0]        merged
);
	logic [W-1:0] or_c;
	logic [W-1:0] or_q;

	// OR of masked words, at most one nonzero
	always_comb begin
		or_c = '0;
		for (int i = 0; i < N; i++) begin
			or_c = or_c | words[i];
		end
	end

	always_ff @(posedge clk) begin
		or_q <= or_c;
	end

	assign merged = or_q;

endmodule

// ----- rtl/indexed_insert_delete_list_top.sv -----
// Position-addressed list of signed 32-bit words, CAPACITY entries deep.
// Requests arrive on the s_ stream: tuser carries the request code (insert,
// read, delete), tdata carries the position and the value to insert.
// Each request yields exactly one result word on the m_ stream: tuser is the
// success flag, tdata holds the read data (zero unless a successful read)
// and the entry count after the request.
// An accepted request passes the EXEC, GRP and OUT states and is then
// loaded into the output register; no new request is taken before that.
// The list cells shift in EXEC, then the read word passes a two-level OR
// reduction (groups of 32 cells, registered, then the group results).
// One request is in flight at a time; the next one is accepted while its
// predecessor's result still waits in the output register.
// If the receiver stalls, the finished result is held and s_tready stays low
// once the next request has reached the output stage.
// Reset clears the count and the handshake state; entry contents are
// undefined until written, and only written positions can be read.
module indexed_insert_delete_list_top #(
	parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [6:0] position, [38:7] item_value, [39] zero
	input  logic [iidl_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] req_type
	input  logic [iidl_pkg::REQ_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] read_value, [38:32] entry_count, [39] zero
	output logic [iidl_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] ok
	output logic                          m_tuser
);
	import iidl_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int NGRP  = (CAPACITY + GROUP_W - 1) / GROUP_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	fsm_t state_q, state_nxt;

	logic [CW-1:0]     count_q;
	logic [REQ_W-1:0]  op_q;
	logic [CW-1:0]     pos_q;
	logic [DATA_W-1:0] val_q;
	logic              ok_q;

	logic              m_tvalid_q;
	logic              out_ok_q;
	logic [DATA_W-1:0] out_rd_q;
	logic [POS_W-1:0]  out_cnt_q;

	logic              accept;
	logic              load_out;
	cell_ctrl_t        ctrl;

	logic [CW-1:0]     in_pos;
	logic [REQ_W-1:0]  in_op;
	logic              in_ok;

	logic [CAPACITY-1:0][DATA_W-1:0]      ent;
	logic [CAPACITY-1:0][DATA_W-1:0]      rd_w;
	logic [NGRP*GROUP_W-1:0][DATA_W-1:0]  rd_pad;
	logic [NGRP-1:0][DATA_W-1:0]          grp_w;
	logic [DATA_W-1:0]                    rd_all;

	// request decode and range check against the current count
	assign in_op  = s_tuser;
	assign in_pos = CW'(s_tdata[POS_W-1:0]);
	always_comb begin
		case (in_op)
			REQ_INSERT: in_ok = (in_pos <= count_q) && (count_q < CAP_C);
			REQ_READ:   in_ok = in_pos < count_q;
			REQ_DELETE: in_ok = in_pos < count_q;
			default:    in_ok = 1'b0;
		endcase
	end

	// sequencer: next state, handshake and cell commands
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		load_out  = 1'b0;
		ctrl      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctrl.ins  = ok_q && (op_q == REQ_INSERT);
				ctrl.del  = ok_q && (op_q == REQ_DELETE);
				state_nxt = ST_GRP;
			end
			ST_GRP: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_op;
			pos_q <= in_pos;
			val_q <= s_tdata[POS_W +: DATA_W];
		end
	end

	// control: success flag and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				ok_q <= in_ok;
			end
			if (ctrl.ins) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.del) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// row of list cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = ent[i+1];
		end
		iidl_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.pos        (pos_q),
			.ins_val    (val_q),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (ent[i]),
			.rd_word    (rd_w[i])
		);
	end

	// pad the read words to whole groups
	always_comb begin
		rd_pad = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_pad[i] = rd_w[i];
		end
	end

	// first reduction level, registered per group
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		iidl_grp_or #(
			.N (GROUP_W),
			.W (DATA_W)
		) u_grp (
			.clk    (clk),
			.words  (rd_pad[g*GROUP_W +: GROUP_W]),
			.merged (grp_w[g])
		);
	end

	// second reduction level feeds the output register
	always_comb begin
		rd_all = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_all = rd_all | grp_w[g];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ok_q  <= ok_q;
			out_rd_q  <= (ok_q && (op_q == REQ_READ)) ? rd_all : '0;
			out_cnt_q <= count_q[POS_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = {{(M_TDATA_W - DATA_W - POS_W){1'b0}}, out_cnt_q, out_rd_q};

endmodule

// ----- bench/indexed_insert_delete_list_top_test.sv -----
module indexed_insert_delete_list_top_test;
	import iidl_pkg::*;

	localparam int LIST_CAP   = CAPACITY_DEF;
	localparam int RAND_WORDS = 1000;
	localparam int DRAIN_WAIT = 10;
	localparam int HANG_LIMIT = 2000;

	// code with no operation behind it
	localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] rd;
		logic [POS_W-1:0]  cnt;
	} list_result_t;

	typedef struct {
		logic [REQ_W-1:0]  req;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		bit                typed;
		list_result_t      res;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [REQ_W-1:0]     s_tuser = REQ_READ;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	// model of the list contents
	logic [DATA_W-1:0] list_mem[LIST_CAP];
	int                list_len;

	list_result_t result_q[$];
	stim_row_t    dir_tab[$];
	int           err_n;
	int           in_n;
	int           hang_n;
	int           gen_len;
	bit           idle_on;

	indexed_insert_delete_list_top #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// apply one request to the list model and return its result
	function automatic list_result_t apply_request(logic [REQ_W-1:0] req,
			logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		list_result_t r;
		int i;
		r = '0;
		case (req)
			REQ_INSERT: begin
				if (pos <= list_len && list_len < LIST_CAP) begin
					for (i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = val;
					list_len++;
					r.ok = 1'b1;
				end
			end
			REQ_READ: begin
				if (pos < list_len) begin
					r.rd = list_mem[pos];
					r.ok = 1'b1;
				end
			end
			REQ_DELETE: begin
				if (pos < list_len) begin
					for (i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.cnt = list_len[POS_W-1:0];
		return r;
	endfunction

	function automatic void add_row(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] val, bit typed, logic ok, logic [DATA_W-1:0] rd,
			logic [POS_W-1:0] cnt);
		stim_row_t row;
		row.req = req;
		row.pos = pos;
		row.val = val;
		row.typed = typed;
		row.res = '{ok: ok, rd: rd, cnt: cnt};
		dir_tab.push_back(row);
	endfunction

	task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
			logic [DATA_W-1:0] want);
		$display("mismatch: result %s got %h want %h at %0t", field, got, want, $realtime);
		err_n++;
	endtask

	// drive one request word and hold it until the block takes it
	task automatic send_word(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] val);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, val, pos};
		s_tuser  <= req;
		do @(posedge clk); while (!s_tready);
		// track the count for shaping later requests
		if (req == REQ_INSERT && pos <= gen_len && gen_len < LIST_CAP)
			gen_len++;
		else if (req == REQ_DELETE && pos < gen_len)
			gen_len--;
	endtask

	task automatic wait_results_done;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (result_q.size() != 0);
	endtask

	// input side: predict on acceptance; output side: compare with oldest
	always @(posedge clk) begin
		list_result_t want;
		list_result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = apply_request(s_tuser, s_tdata[POS_W-1:0],
					s_tdata[POS_W+DATA_W-1:POS_W]);
				if (in_n < dir_tab.size() && dir_tab[in_n].typed)
					want = dir_tab[in_n].res;
				result_q.push_back(want);
				in_n++;
			end
			if (m_tvalid && m_tready) begin
				got = '{ok: m_tuser, rd: m_tdata[DATA_W-1:0],
					cnt: m_tdata[DATA_W+POS_W-1:DATA_W]};
				if (result_q.size() == 0) begin
					$display("unexpected result word %h/%b at %0t", m_tdata, m_tuser,
						$realtime);
					err_n++;
				end else begin
					want = result_q.pop_front();
					if (got.ok !== want.ok)
						report_mismatch("ok", DATA_W'(got.ok), DATA_W'(want.ok));
					if (got.rd !== want.rd)
						report_mismatch("read_value", got.rd, want.rd);
					if (got.cnt !== want.cnt)
						report_mismatch("entry_count", DATA_W'(got.cnt),
							DATA_W'(want.cnt));
				end
			end
			// watchdog on cycles with no word moving on either side
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				hang_n = 0;
			else
				hang_n++;
			if (hang_n >= HANG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// receiver with random stall bursts
	initial begin
		@(posedge arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// stimulus
	initial begin
		logic [REQ_W-1:0]  req;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		bit                fill_mode;
		int                r;
		int                n;

		err_n = 0;
		in_n = 0;
		hang_n = 0;
		list_len = 0;
		gen_len = 0;
		idle_on = 1'b1;
		fill_mode = 1'b1;
		foreach (list_mem[i])
			list_mem[i] = '0;

		// empty list: everything but insert at 0 fails
		add_row(REQ_READ,   7'd0,   32'h0000_0000, 1, 1'b0, 32'h0, 7'd0);
		add_row(REQ_DELETE, 7'd0,   32'h0000_0000, 1, 1'b0, 32'h0, 7'd0);
		add_row(REQ_INSERT, 7'd1,   32'h0000_0001, 1, 1'b0, 32'h0, 7'd0);
		add_row(REQ_INSERT, 7'd127, 32'hFFFF_FFFF, 1, 1'b0, 32'h0, 7'd0);
		add_row(REQ_NONE,   7'd0,   32'h1234_5678, 1, 1'b0, 32'h0, 7'd0);
		// value extremes, insert at front and at end
		add_row(REQ_INSERT, 7'd0,   32'h7FFF_FFFF, 1, 1'b1, 32'h0, 7'd1);
		add_row(REQ_INSERT, 7'd0,   32'h8000_0000, 1, 1'b1, 32'h0, 7'd2);
		add_row(REQ_INSERT, 7'd2,   32'h0000_0000, 1, 1'b1, 32'h0, 7'd3);
		add_row(REQ_INSERT, 7'd4,   32'h0000_0001, 1, 1'b0, 32'h0, 7'd3);
		add_row(REQ_READ,   7'd0,   32'h0000_0000, 1, 1'b1, 32'h8000_0000, 7'd3);
		add_row(REQ_READ,   7'd1,   32'h0000_0000, 1, 1'b1, 32'h7FFF_FFFF, 7'd3);
		add_row(REQ_READ,   7'd2,   32'h0000_0000, 1, 1'b1, 32'h0000_0000, 7'd3);
		add_row(REQ_READ,   7'd3,   32'h0000_0000, 1, 1'b0, 32'h0, 7'd3);
		add_row(REQ_READ,   7'd127, 32'h0000_0000, 1, 1'b0, 32'h0, 7'd3);
		add_row(REQ_DELETE, 7'd3,   32'h0000_0000, 1, 1'b0, 32'h0, 7'd3);
		add_row(REQ_DELETE, 7'd127, 32'h0000_0000, 1, 1'b0, 32'h0, 7'd3);
		// shifting in the middle
		add_row(REQ_INSERT, 7'd1,   32'h5555_5555, 0, 1'b0, 32'h0, 7'd0);
		add_row(REQ_INSERT, 7'd1,   32'hAAAA_AAAA, 0, 1'b0, 32'h0, 7'd0);
		add_row(REQ_READ,   7'd2,   32'h0000_0000, 0, 1'b0, 32'h0, 7'd0);
		add_row(REQ_DELETE, 7'd1,   32'h0000_0000, 0, 1'b0, 32'h0, 7'd0);
		add_row(REQ_READ,   7'd1,   32'h0000_0000, 0, 1'b0, 32'h0, 7'd0);
		add_row(REQ_DELETE, 7'd0,   32'h0000_0000, 0, 1'b0, 32'h0, 7'd0);
		add_row(REQ_DELETE, 7'd2,   32'h0000_0000, 0, 1'b0, 32'h0, 7'd0);
		add_row(REQ_NONE,   7'd127, 32'hFFFF_FFFF, 1, 1'b0, 32'h0, 7'd2);
		add_row(REQ_READ,   7'd1,   32'hFFFF_FFFF, 0, 1'b0, 32'h0, 7'd0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i].req, dir_tab[i].pos, dir_tab[i].val);
		wait_results_done();

		// random part: alternate fill and drain so full and empty recur
		for (n = 0; n < RAND_WORDS; n++) begin
			idle_on = (n < RAND_WORDS * 85 / 100) && ((n / 100) % 3 != 2);
			if (n == RAND_WORDS / 2)
				wait_results_done();
			if (gen_len == LIST_CAP && $urandom_range(0, 3) == 0)
				fill_mode = 1'b0;
			else if (gen_len == 0 && $urandom_range(0, 3) == 0)
				fill_mode = 1'b1;

			r = $urandom_range(0, 99);
			if (fill_mode)
				req = (r < 65) ? REQ_INSERT : (r < 85) ? REQ_READ :
					(r < 97) ? REQ_DELETE : REQ_NONE;
			else
				req = (r < 20) ? REQ_INSERT : (r < 35) ? REQ_READ :
					(r < 97) ? REQ_DELETE : REQ_NONE;

			// mostly in-range positions, ends favored, some noise
			if ($urandom_range(0, 9) == 0)
				pos = POS_W'($urandom_range(0, 127));
			else if (req == REQ_INSERT)
				pos = ($urandom_range(0, 3) == 0) ?
					(($urandom_range(0, 1) == 0) ? '0 : POS_W'(gen_len))
					: POS_W'($urandom_range(0, gen_len));
			else if (gen_len == 0)
				pos = '0;
			else
				pos = ($urandom_range(0, 3) == 0) ?
					(($urandom_range(0, 1) == 0) ? '0 : POS_W'(gen_len - 1))
					: POS_W'($urandom_range(0, gen_len - 1));
			val = $urandom;
			send_word(req, pos, val);
		end

		wait_results_done();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_n == 0 && result_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/iidl_pkg.sv
rtl/iidl_cell.sv
rtl/iidl_grp_or.sv
rtl/indexed_insert_delete_list_top.sv
bench/indexed_insert_delete_list_top_test.sv
